// ===== sv/sm3c_pkg.sv =====
// ----------------------------------------------------------------------------
// sm3c_pkg: shared constants, types and functions for the SM3 lane array
// Lane counts, round constants, request codes, the sequencer-to-lane
// control struct and the SM3 bit-mixing functions.
// ----------------------------------------------------------------------------
package sm3c_pkg;

  // Lane counts: cores built, and lanes that have ports
  localparam int LANES      = 8;
  localparam int PORT_LANES = 8;

  // Block geometry
  localparam int CV_WORDS  = 8;
  localparam int MSG_WORDS = 16;
  localparam int ROUNDS    = 64;
  localparam int FF_SWITCH = 16;

  localparam logic [31:0] T_LOW  = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h7A879D8A;

  // Request codes on req_type
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_MSG  = 1'b1;

  // Sequencer to lane control
  typedef struct packed {
    logic       load_en;   // write one chaining word in every lane
    logic [2:0] load_idx;
    logic       msg_en;    // shift one message word into every lane
    logic       msg_last;  // the sixteenth word: take snapshot and active bit
    logic       rnd_en;    // run one compression round
    logic [5:0] rnd_idx;
    logic       finish;    // last round: fold result into chaining state
    logic [2:0] rd_idx;    // chaining word shown on the read port
  } ctl_t;

  function automatic logic [31:0] rotl32(logic [31:0] x, int n);
    rotl32 = (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] perm0(logic [31:0] x);
    perm0 = x ^ rotl32(x, 9) ^ rotl32(x, 17);
  endfunction

  function automatic logic [31:0] perm1(logic [31:0] x);
    perm1 = x ^ rotl32(x, 15) ^ rotl32(x, 23);
  endfunction

  // Round constant T_j rotated left by j mod 32
  function automatic logic [31:0] t_const(logic [5:0] j);
    logic [31:0] base;
    logic [63:0] dbl;
    base = (j < 6'(FF_SWITCH)) ? T_LOW : T_HIGH;
    dbl = {base, base} << j[4:0];
    t_const = dbl[63:32];
  endfunction

endpackage

// ===== sv/sm3_compress_8lane.sv =====
// ----------------------------------------------------------------------------
// sm3_compress_8lane: eight-lane SM3 compression
// Eight SM3 cores run side by side on one message block each; the merge
// stage gathers one chaining word from every lane into each result word.
//
//   channel | handshake                     | payload
//   --------+-------------------------------+-------------------------------
//   in      | in_valid_i / in_stall_o       | req_type, reg_index,
//           |                               | lane_active, lane0..7_word
//   out     | out_valid_o / out_stall_i     | out_index, out_lane0..7,
//           |                               | out_last
//
// Load words and message words are taken while in_stall_o is low. The
// sixteenth message word starts 64 rounds at one per cycle in every lane,
// then eight result words follow, one per cycle when out_stall_i is low.
// Input is stalled from the cycle after the sixteenth word until the last
// result word is taken. Reset clears the chaining state.
// ----------------------------------------------------------------------------
module sm3_compress_8lane (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [2:0]  reg_index_i,
  input  logic [7:0]  lane_active_i,
  input  logic [31:0] lane0_word_i,
  input  logic [31:0] lane1_word_i,
  input  logic [31:0] lane2_word_i,
  input  logic [31:0] lane3_word_i,
  input  logic [31:0] lane4_word_i,
  input  logic [31:0] lane5_word_i,
  input  logic [31:0] lane6_word_i,
  input  logic [31:0] lane7_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  out_index_o,
  output logic [31:0] out_lane0_o,
  output logic [31:0] out_lane1_o,
  output logic [31:0] out_lane2_o,
  output logic [31:0] out_lane3_o,
  output logic [31:0] out_lane4_o,
  output logic [31:0] out_lane5_o,
  output logic [31:0] out_lane6_o,
  output logic [31:0] out_lane7_o,
  output logic        out_last_o
);

  sm3c_pkg::ctl_t ctl;
  logic [31:0]    port_in  [sm3c_pkg::PORT_LANES];
  logic [31:0]    port_out [sm3c_pkg::PORT_LANES];
  logic [31:0]    lane_rd  [sm3c_pkg::LANES];

  assign port_in[0] = lane0_word_i;
  assign port_in[1] = lane1_word_i;
  assign port_in[2] = lane2_word_i;
  assign port_in[3] = lane3_word_i;
  assign port_in[4] = lane4_word_i;
  assign port_in[5] = lane5_word_i;
  assign port_in[6] = lane6_word_i;
  assign port_in[7] = lane7_word_i;

  // Sequencer
  sm3c_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .reg_index_i (reg_index_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_index_o (out_index_o),
    .out_last_o  (out_last_o),
    .ctl_o       (ctl)
  );

  // Lanes; a lane without a port sees zero words and is never active
  for (genvar l = 0; l < sm3c_pkg::LANES; l++) begin : g_lane
    logic [31:0] word;
    logic        act;
    if (l < sm3c_pkg::PORT_LANES) begin : g_port
      assign word = port_in[l];
      assign act  = lane_active_i[l];
    end else begin : g_noport
      assign word = '0;
      assign act  = 1'b0;
    end
    sm3c_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .word_i    (word),
      .active_i  (act),
      .rd_word_o (lane_rd[l])
    );
  end

  // Merge: one chaining word from every lane per result word
  for (genvar l = 0; l < sm3c_pkg::PORT_LANES; l++) begin : g_merge
    if (l < sm3c_pkg::LANES) begin : g_have
      assign port_out[l] = lane_rd[l];
    end else begin : g_none
      assign port_out[l] = '0;
    end
  end

  assign out_lane0_o = port_out[0];
  assign out_lane1_o = port_out[1];
  assign out_lane2_o = port_out[2];
  assign out_lane3_o = port_out[3];
  assign out_lane4_o = port_out[4];
  assign out_lane5_o = port_out[5];
  assign out_lane6_o = port_out[6];
  assign out_lane7_o = port_out[7];

endmodule

// ===== sv/sm3c_lane.sv =====
// ----------------------------------------------------------------------------
// sm3c_lane: one SM3 compression core
// Holds the lane's chaining state, a sixteen-word message window that also
// runs the message expansion, and the working registers A..H. One round per
// cycle while the sequencer drives rnd_en.
// ----------------------------------------------------------------------------
module sm3c_lane (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sm3c_pkg::ctl_t  ctl_i,
  input  logic [31:0]     word_i,
  input  logic            active_i,
  output logic [31:0]     rd_word_o
);

  logic [31:0] chain_q [sm3c_pkg::CV_WORDS];
  logic [31:0] chain_d [sm3c_pkg::CV_WORDS];
  logic [31:0] work_q  [sm3c_pkg::CV_WORDS];
  logic [31:0] work_d  [sm3c_pkg::CV_WORDS];
  logic [31:0] win_q   [sm3c_pkg::MSG_WORDS];
  logic        active_q;

  logic [31:0] a12, sum1, ss1, ss2, ff, gg, tt1, tt2, w_new, w_in;

  // Round datapath
  always_comb begin
    a12  = sm3c_pkg::rotl32(work_q[0], 12);
    sum1 = a12 + work_q[4] + sm3c_pkg::t_const(ctl_i.rnd_idx);
    ss1  = sm3c_pkg::rotl32(sum1, 7);
    ss2  = ss1 ^ a12;
    if (ctl_i.rnd_idx < 6'(sm3c_pkg::FF_SWITCH)) begin
      ff = work_q[0] ^ work_q[1] ^ work_q[2];
      gg = work_q[4] ^ work_q[5] ^ work_q[6];
    end else begin
      ff = (work_q[0] & work_q[1]) | (work_q[0] & work_q[2]) | (work_q[1] & work_q[2]);
      gg = (work_q[4] & work_q[5]) | (~work_q[4] & work_q[6]);
    end
    tt1 = ff + work_q[3] + ss2 + (win_q[0] ^ win_q[4]);
    tt2 = gg + work_q[7] + ss1 + win_q[0];
    work_d[0] = tt1;
    work_d[1] = work_q[0];
    work_d[2] = sm3c_pkg::rotl32(work_q[1], 9);
    work_d[3] = work_q[2];
    work_d[4] = sm3c_pkg::perm0(tt2);
    work_d[5] = work_q[4];
    work_d[6] = sm3c_pkg::rotl32(work_q[5], 19);
    work_d[7] = work_q[6];
  end

  // Message expansion: W[j+16] from the window
  assign w_new = sm3c_pkg::perm1(win_q[0] ^ win_q[7] ^ sm3c_pkg::rotl32(win_q[13], 15))
               ^ sm3c_pkg::rotl32(win_q[3], 7) ^ win_q[10];
  assign w_in  = ctl_i.msg_en ? word_i : w_new;

  // Message window: shifts on a message word and on every round
  always_ff @(posedge clk_i) begin
    if (ctl_i.msg_en || ctl_i.rnd_en) begin
      for (int i = 0; i < sm3c_pkg::MSG_WORDS - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[sm3c_pkg::MSG_WORDS-1] <= w_in;
    end
  end

  // Working registers: snapshot at block start, then one round a cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.msg_en && ctl_i.msg_last) begin
      work_q <= chain_q;
    end else if (ctl_i.rnd_en) begin
      work_q <= work_d;
    end
  end

  // Active bit of the block, taken with its sixteenth word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (ctl_i.msg_en && ctl_i.msg_last) begin
      active_q <= active_i;
    end
  end

  // Chaining state: loads, and the feed-forward XOR at block end in active lanes
  always_comb begin
    chain_d = chain_q;
    if (ctl_i.load_en) begin
      chain_d[ctl_i.load_idx] = word_i;
    end else if (ctl_i.finish && active_q) begin
      for (int k = 0; k < sm3c_pkg::CV_WORDS; k++) begin
        chain_d[k] = chain_q[k] ^ work_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < sm3c_pkg::CV_WORDS; k++) begin
        chain_q[k] <= '0;
      end
    end else begin
      chain_q <= chain_d;
    end
  end

  assign rd_word_o = chain_q[ctl_i.rd_idx];

endmodule

// ===== sv/sm3c_ctrl.sv =====
// ----------------------------------------------------------------------------
// sm3c_ctrl: block sequencer
// Counts message words, steps the 64 rounds and walks the eight result
// words out; drives both handshakes and the lane control struct.
// ----------------------------------------------------------------------------
module sm3c_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            req_type_i,
  input  logic [2:0]      reg_index_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [2:0]      out_index_o,
  output logic            out_last_o,
  output sm3c_pkg::ctl_t  ctl_o
);

  typedef enum logic [2:0] {
    S_MSG = 3'b001,
    S_RND = 3'b010,
    S_OUT = 3'b100
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [5:0] rnd_q, rnd_d;
  logic [2:0] oidx_q, oidx_d;
  logic       in_acc, out_acc, msg_acc, last_word, last_rnd;

  assign in_stall_o  = (state_q != S_MSG);
  assign out_valid_o = (state_q == S_OUT);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign msg_acc     = in_acc && (req_type_i == sm3c_pkg::REQ_MSG);
  assign last_word   = (cnt_q == 4'(sm3c_pkg::MSG_WORDS - 1));
  assign last_rnd    = (rnd_q == 6'(sm3c_pkg::ROUNDS - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rnd_d   = rnd_q;
    oidx_d  = oidx_q;
    unique case (state_q)
      S_MSG: begin
        if (msg_acc) begin
          cnt_d = cnt_q + 4'd1;
          if (last_word) begin
            state_d = S_RND;
            rnd_d   = '0;
          end
        end
      end
      S_RND: begin
        rnd_d = rnd_q + 6'd1;
        if (last_rnd) begin
          state_d = S_OUT;
          oidx_d  = '0;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'(sm3c_pkg::CV_WORDS - 1)) begin
            state_d = S_MSG;
          end
        end
      end
      default: begin
        state_d = S_MSG;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_MSG;
      cnt_q   <= '0;
      rnd_q   <= '0;
      oidx_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rnd_q   <= rnd_d;
      oidx_q  <= oidx_d;
    end
  end

  // Lane control
  always_comb begin
    ctl_o.load_en  = in_acc && (req_type_i == sm3c_pkg::REQ_LOAD);
    ctl_o.load_idx = reg_index_i;
    ctl_o.msg_en   = msg_acc;
    ctl_o.msg_last = last_word;
    ctl_o.rnd_en   = (state_q == S_RND);
    ctl_o.rnd_idx  = rnd_q;
    ctl_o.finish   = (state_q == S_RND) && last_rnd;
    ctl_o.rd_idx   = oidx_q;
  end

  assign out_index_o = oidx_q;
  assign out_last_o  = (oidx_q == 3'(sm3c_pkg::CV_WORDS - 1));

`ifndef SYNTHESIS
  a_start_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (msg_acc && last_word) |=> (state_q == S_RND && rnd_q == 6'd0))
    else $error("rounds did not start after the sixteenth word");

  a_rounds_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RND && last_rnd) |=> (state_q == S_OUT && oidx_q == 3'd0))
    else $error("results did not follow the last round");

  a_block_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_last_o) |=> (state_q == S_MSG && cnt_q == 4'd0))
    else $error("block did not close after the last result word");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_MSG) |-> (cnt_q == 4'd0))
    else $error("word count not clear outside message phase");
`endif

endmodule
